### src/mmcv_pkg.sv
// Shared types, constants and arithmetic helpers of the monophonic MIDI-to-CV voice.
package mmcv_pkg;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF  = 8;
    localparam int MAX_BEND_RANGE_DEF = 12;
    localparam int DEFAULT_NOTE_DEF   = 60;

    // Register reset values
    localparam logic        VOICE_MODE_RST = 1'b0;
    localparam logic [10:0] STEP_SIZE_RST  = 11'd546;
    localparam logic [3:0]  BEND_RANGE_RST = 4'd2;

    localparam int          MIDDLE_NOTE  = 60;
    localparam int          SCALE_OFFSET = 32768;   // 0x800 << 4
    localparam logic [11:0] CV_MAX       = 12'hfff;
    localparam logic [6:0]  DAMPER_CC    = 7'd64;
    localparam logic [6:0]  DAMPER_DOWN  = 7'h7f;
    localparam logic [6:0]  DAMPER_UP    = 7'h00;
    localparam int          BEND_SHIFT   = 13;

    // Shared shift-add multiplier: 12 multiplier bits, 26-bit signed accumulator
    localparam int MUL_BITS = 12;
    localparam int ACC_W    = 26;

    typedef enum logic [1:0] {
        KIND_NOTE_OFF = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_CTRL     = 2'd2,
        KIND_BEND     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_VOICE_MODE = 2'd0,
        CFG_STEP_SIZE  = 2'd1,
        CFG_BEND_RANGE = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_NOTE,
        PH_BEND_BASE,
        PH_BEND_SIDE,
        PH_BEND_MUL
    } t_phase;

    // Sign-extend a 9-bit note offset to the accumulator width
    function automatic logic [ACC_W-1:0] sext9(input logic [8:0] x);
        return {{(ACC_W-9){x[8]}}, x};
    endfunction

    // (32768 + prod) / 16, clamped to 0..4095
    function automatic logic [11:0] scale_fin(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] v;
        v = acc + ACC_W'(SCALE_OFFSET);
        if (v[ACC_W-1]) begin
            return '0;
        end else if (|v[ACC_W-2:16]) begin
            return CV_MAX;
        end else begin
            return v[15:4];
        end
    endfunction

    // scale + signed bend, saturated to 0..4095
    function automatic logic [11:0] cv_clamp(input logic [11:0] sc,
                                             input logic [12:0] bend);
        logic [13:0] s;
        s = {2'b00, sc} + {bend[12], bend};
        if (s[13]) begin
            return '0;
        end else if (s[12]) begin
            return CV_MAX;
        end else begin
            return s[11:0];
        end
    endfunction

endpackage

### src/mono_midi_to_cv_voice_unit.sv
// Monophonic last-note-priority MIDI-to-CV voice with a bit-serial scale and bend unit.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: data_first,
//            |     |                              |   data_second
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: cv_value, cv_written,
//            |     |                              |   gate_level, gate_written
//  cfg       | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Flow: one request at a time. A note event scans the held-note ring one slot per cycle,
// may walk back through it for the fallback note and runs at most one multiplier pass.
// A pitch bend runs three passes, a damper release at most one, other events none.
// Reset: synchronous, active low; clears the ring's valid bits, damper, bend and registers.
// Stalls: a waiting result holds in the output register; only the next result stalls.
module mono_midi_to_cv_voice_unit
    import mmcv_pkg::*;
#(
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF,
    parameter int MAX_BEND_RANGE = MAX_BEND_RANGE_DEF,
    parameter int DEFAULT_NOTE   = DEFAULT_NOTE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] data_first, [13:7] data_second, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] cv_value, [12] cv_written,
                                        // [13] gate_level, [14] gate_written, [15] zero

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int IDXW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(HISTORY_DEPTH - 1);
    localparam logic [6:0] NOTE_LO = 7'(MAX_BEND_RANGE);
    localparam logic [6:0] NOTE_HI = 7'(127 - MAX_BEND_RANGE);

    // control state
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic r_mode, n_mode;
    logic [10:0] r_step, n_step;
    logic [3:0] r_range, n_range;
    logic [HISTORY_DEPTH-1:0] r_valid, n_valid;
    logic [IDXW-1:0] r_newest, n_newest;
    logic r_damper, n_damper;
    logic [6:0] r_note, n_note;
    logic [12:0] r_bend, n_bend;
    logic r_ovalid, n_ovalid;

    // payload
    logic [6:0] r_hist [HISTORY_DEPTH];
    logic [6:0] r_hist_rd;
    logic hist_we;
    logic [IDXW-1:0] hist_waddr;
    t_kind r_kind, n_kind;
    logic [6:0] r_d1, n_d1, r_d2, n_d2;
    logic [IDXW-1:0] r_idx, n_idx;
    logic r_held, n_held;
    logic [ACC_W-1:0] r_acc, n_acc, r_mcand, n_mcand;
    logic [MUL_BITS-1:0] r_mplier, n_mplier;
    logic [3:0] r_mcnt, n_mcnt;
    logic [11:0] r_sc0, n_sc0;
    logic [11:0] r_pcv, n_pcv;
    logic r_pcvw, n_pcvw, r_pgate, n_pgate, r_pgw, n_pgw;
    logic [11:0] r_ocv, n_ocv;
    logic r_ocvw, n_ocvw, r_ogate, n_ogate, r_ogw, n_ogw;

    // request decode
    logic in_acc;
    t_kind in_kind;
    logic [6:0] in_d1, in_d2;
    logic in_note_ok, in_release;

    // scan/search helpers
    logic scan_last, valid_cur, keep_cur, held_fin, newest_after;
    logic [IDXW-1:0] newest_inc, idx_dec, newest_dec;

    // arithmetic helpers
    logic mul_done, out_free, b_neg;
    logic [13:0] b_val;
    logic [8:0] x_side;
    logic [11:0] sc_now, d_diff;
    logic [12:0] bend_new;

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign in_kind = t_kind'(s_axis_tuser);
    assign in_d1   = s_axis_tdata[6:0];
    assign in_d2   = s_axis_tdata[13:7];
    assign in_note_ok = ((in_kind == KIND_NOTE_OFF) || (in_kind == KIND_NOTE_ON))
                        && (in_d1 >= NOTE_LO) && (in_d1 <= NOTE_HI);
    // damper up with no note held releases the gate
    assign in_release = (in_kind == KIND_CTRL) && (in_d1 == DAMPER_CC)
                        && (in_d2 == DAMPER_UP) && !(|r_valid);

    // r_hist_rd holds the ring entry at r_idx (read at the previous edge with n_idx)
    assign scan_last    = (r_idx == LAST_SLOT);
    assign valid_cur    = r_valid[r_idx];
    assign keep_cur     = valid_cur && (r_hist_rd != r_d1);
    assign held_fin     = r_held | keep_cur;
    assign newest_after = (r_newest == r_idx) ? keep_cur : r_valid[r_newest];
    assign newest_inc   = (r_newest == LAST_SLOT) ? '0 : r_newest + IDXW'(1);
    assign newest_dec   = (r_newest == '0) ? LAST_SLOT : r_newest - IDXW'(1);
    assign idx_dec      = (r_idx == '0) ? LAST_SLOT : r_idx - IDXW'(1);

    assign mul_done = (r_mcnt == 4'(MUL_BITS));
    assign out_free = !r_ovalid || m_axis_tready;
    // bend = {d2,d1} - 8192: flip the top bit; negative when d2[6] is clear
    assign b_neg    = ~r_d2[6];
    assign b_val    = {~r_d2[6], r_d2[5:0], r_d1};
    assign x_side   = b_neg ? ({2'b00, r_note} - 9'(MIDDLE_NOTE) - {5'b0, r_range})
                            : ({2'b00, r_note} - 9'(MIDDLE_NOTE) + {5'b0, r_range});
    assign sc_now   = scale_fin(r_acc);
    assign d_diff   = b_neg ? (r_sc0 - sc_now) : (sc_now - r_sc0);
    assign bend_new = r_acc[ACC_W-1:BEND_SHIFT];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_note_ok) begin
                        n_state = ST_SCAN;
                    end else if (in_kind == KIND_BEND) begin
                        n_state = ST_MUL;
                    end else if (in_release) begin
                        n_state = r_mode ? ST_EMIT : ST_MUL;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    if (r_kind == KIND_NOTE_ON) begin
                        if (!r_mode) begin
                            n_state = ST_MUL;
                        end else begin
                            n_state = held_fin ? ST_IDLE : ST_EMIT;
                        end
                    end else if (newest_after) begin
                        n_state = ST_IDLE;
                    end else if (held_fin) begin
                        n_state = ST_SEARCH;
                    end else if (r_damper) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = r_mode ? ST_EMIT : ST_MUL;
                    end
                end
            end
            ST_SEARCH: begin
                if (valid_cur) begin
                    n_state = r_mode ? ST_IDLE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done && (r_phase == PH_NOTE || r_phase == PH_BEND_MUL)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // port outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        o_cfg_ready   = 1'b1;
        m_axis_tvalid = r_ovalid;
        m_axis_tdata  = {1'b0, r_ogw, r_ogate, r_ocvw, r_ocv};
    end

    // datapath
    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_step   = r_step;
        n_range  = r_range;
        n_valid  = r_valid;
        n_newest = r_newest;
        n_damper = r_damper;
        n_note   = r_note;
        n_bend   = r_bend;
        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_d1     = r_d1;
        n_d2     = r_d2;
        n_idx    = r_idx;
        n_held   = r_held;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_mcnt   = r_mcnt;
        n_sc0    = r_sc0;
        n_pcv    = r_pcv;
        n_pcvw   = r_pcvw;
        n_pgate  = r_pgate;
        n_pgw    = r_pgw;
        n_ocv    = r_ocv;
        n_ocvw   = r_ocvw;
        n_ogate  = r_ogate;
        n_ogw    = r_ogw;
        hist_we    = 1'b0;
        hist_waddr = newest_inc;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VOICE_MODE: n_mode  = i_cfg_data[0];
                CFG_STEP_SIZE:  n_step  = i_cfg_data;
                CFG_BEND_RANGE: n_range = i_cfg_data[3:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_kind = in_kind;
                    n_d1   = in_d1;
                    n_d2   = in_d2;
                    n_idx  = '0;
                    n_held = 1'b0;
                    if ((in_kind == KIND_CTRL) && (in_d1 == DAMPER_CC)) begin
                        if (in_d2 == DAMPER_DOWN) begin
                            n_damper = 1'b1;
                        end else if (in_d2 == DAMPER_UP) begin
                            n_damper = 1'b0;
                        end
                    end
                    // both the bend and a release start with scale(current note)
                    n_acc    = '0;
                    n_mcand  = sext9({2'b00, r_note} - 9'(MIDDLE_NOTE));
                    n_mplier = {1'b0, r_step};
                    n_mcnt   = '0;
                    n_phase  = (in_kind == KIND_BEND) ? PH_BEND_BASE : PH_NOTE;
                    n_pcv    = '0;
                    n_pcvw   = 1'b0;
                    n_pgate  = 1'b0;
                    n_pgw    = (in_kind != KIND_BEND);
                end
            end
            ST_SCAN: begin
                n_valid[r_idx] = keep_cur;
                n_held = held_fin;
                n_idx  = r_idx + IDXW'(1);
                if (scan_last) begin
                    n_acc    = '0;
                    n_mplier = {1'b0, r_step};
                    n_mcnt   = '0;
                    n_phase  = PH_NOTE;
                    n_mcand  = sext9({2'b00, r_d1} - 9'(MIDDLE_NOTE));
                    if (r_kind == KIND_NOTE_ON) begin
                        hist_we    = 1'b1;
                        hist_waddr = newest_inc;
                        n_newest   = newest_inc;
                        n_valid[newest_inc] = 1'b1;
                        n_note  = r_mode ? r_note : r_d1;
                        n_pcv   = {r_d2, 5'b0};
                        n_pcvw  = 1'b1;
                        n_pgate = 1'b1;
                        n_pgw   = 1'b1;
                    end else begin
                        n_idx   = newest_dec;
                        // nothing left held: release with the note just lifted
                        if (!held_fin && !r_damper && !r_mode) begin
                            n_note = r_d1;
                        end
                        n_pcv   = '0;
                        n_pcvw  = 1'b0;
                        n_pgate = 1'b0;
                        n_pgw   = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                n_idx = idx_dec;
                if (valid_cur) begin
                    n_newest = r_idx;
                    n_acc    = '0;
                    n_mplier = {1'b0, r_step};
                    n_mcnt   = '0;
                    n_phase  = PH_NOTE;
                    n_mcand  = sext9({2'b00, r_hist_rd} - 9'(MIDDLE_NOTE));
                    n_pgate  = 1'b1;
                    n_pgw    = 1'b1;
                    if (!r_mode) begin
                        n_note = r_hist_rd;
                    end
                end
            end
            ST_MUL: begin
                if (!mul_done) begin
                    if (r_mplier[0]) begin
                        n_acc = r_acc + r_mcand;
                    end
                    n_mcand  = {r_mcand[ACC_W-2:0], 1'b0};
                    n_mplier = {1'b0, r_mplier[MUL_BITS-1:1]};
                    n_mcnt   = r_mcnt + 4'd1;
                end else begin
                    n_acc  = '0;
                    n_mcnt = '0;
                    case (r_phase)
                        PH_NOTE: begin
                            n_pcv  = cv_clamp(sc_now, r_bend);
                            n_pcvw = 1'b1;
                        end
                        PH_BEND_BASE: begin
                            n_sc0    = sc_now;
                            n_mcand  = sext9(x_side);
                            n_mplier = {1'b0, r_step};
                            n_phase  = PH_BEND_SIDE;
                        end
                        PH_BEND_SIDE: begin
                            n_mcand  = {{(ACC_W-14){b_val[13]}}, b_val};
                            n_mplier = d_diff;
                            n_phase  = PH_BEND_MUL;
                        end
                        PH_BEND_MUL: begin
                            n_bend = bend_new;
                            n_pcv  = cv_clamp(r_sc0, bend_new);
                            n_pcvw = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocv    = r_pcv;
                    n_ocvw   = r_pcvw;
                    n_ogate  = r_pgate;
                    n_ogw    = r_pgw;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_NOTE;
            r_mode   <= VOICE_MODE_RST;
            r_step   <= STEP_SIZE_RST;
            r_range  <= BEND_RANGE_RST;
            r_valid  <= '0;
            r_newest <= '0;
            r_damper <= 1'b0;
            r_note   <= 7'(DEFAULT_NOTE);
            r_bend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_mode   <= n_mode;
            r_step   <= n_step;
            r_range  <= n_range;
            r_valid  <= n_valid;
            r_newest <= n_newest;
            r_damper <= n_damper;
            r_note   <= n_note;
            r_bend   <= n_bend;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_waddr] <= r_d1;
        end
        r_hist_rd <= r_hist[n_idx];
        r_kind   <= n_kind;
        r_d1     <= n_d1;
        r_d2     <= n_d2;
        r_idx    <= n_idx;
        r_held   <= n_held;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_mcnt   <= n_mcnt;
        r_sc0    <= n_sc0;
        r_pcv    <= n_pcv;
        r_pcvw   <= n_pcvw;
        r_pgate  <= n_pgate;
        r_pgw    <= n_pgw;
        r_ocv    <= n_ocv;
        r_ocvw   <= n_ocvw;
        r_ogate  <= n_ogate;
        r_ogw    <= n_ogw;
    end

endmodule
